FILE: rtl/core/qfr_pkg.sv
// Shared types and constants for the record line rewriter.
// No dependencies; compiled first.
package qfr_pkg;

  // Decimal field of the line trailer: the count never exceeds 99999.
  localparam int unsigned DEC_W       = 17;
  localparam int unsigned DIGIT_LIMIT = 99999;
  localparam int unsigned DIGITS      = 5;
  localparam logic [3:0]  FIELD_LIMIT = 4'd11;

  localparam logic [7:0] CH_AT    = 8'h40;  // '@'
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_THREE = 8'h33;  // '3'
  localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_N     = 8'h4E;  // 'N'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'

  // Field indexes with special handling.
  localparam logic [3:0] FLD_DROP  = 4'd6;
  localparam logic [3:0] FLD_FLAG  = 4'd7;
  localparam logic [3:0] FLD_BASES = 4'd8;
  localparam logic [3:0] FLD_QUAL  = 4'd9;
  localparam logic [3:0] FLD_LAST  = 4'd10;

  // Configuration register indexes.
  localparam logic CFG_QUAL_OFFSET = 1'b0;
  localparam logic CFG_QUAL_THRESH = 1'b1;

  // Decimal place values, most significant first.
  localparam logic [DEC_W-1:0] DEC_STEP [DIGITS] = '{
    17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1
  };

  typedef enum logic [1:0] {
    K_NONE,   // nothing but a possible '@'
    K_BYTE,   // one output byte
    K_EOL     // tab, decimal count, newline
  } qfr_kind_t;

  // One command from front to back.
  typedef struct packed {
    logic             lead;   // '@' goes first
    qfr_kind_t        kind;
    logic [7:0]       data;
    logic [DEC_W-1:0] count;
  } qfr_entry_t;

  // Replacement for the tab that closes fields 0..5.
  function automatic logic [7:0] qfr_tab_char(input logic [2:0] fld);
    logic [7:0] c;
    unique case (fld)
      3'd0:    c = CH_UNDER;
      3'd1,
      3'd2,
      3'd3,
      3'd4:    c = CH_COLON;
      3'd5:    c = CH_SLASH;
      default: c = CH_TAB;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/qfr_if.sv
// Stream channel interfaces for the rewriter: input bytes and output bytes.
// No dependencies.
interface qfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface qfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: rtl/core/qfr_queue.sv
// Short command queue between front and back.
// Depends on qfr_pkg.
module qfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qfr_pkg::qfr_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output qfr_pkg::qfr_entry_t head,
  output logic               empty
);
  import qfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qfr_entry_t             mem [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]       cnt_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

FILE: rtl/core/qfr_front.sv
// Front end: takes input bytes, tracks field position and quality count,
// and issues output commands. Depends on qfr_pkg and qfr_if.
module qfr_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata,
  qfr_in_if.sink              in_chan,
  input  logic                q_full,
  output logic                push,
  output qfr_pkg::qfr_entry_t push_data
);
  import qfr_pkg::*;

  localparam longint unsigned FULL_CNT = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [COUNT_BITS-1:0] CAP =
    COUNT_BITS'((FULL_CNT < 64'(DIGIT_LIMIT)) ? FULL_CNT : 64'(DIGIT_LIMIT));

  logic [7:0]            qoff_r;
  logic [6:0]            qthr_r;
  logic [3:0]            fld_r, fld_nxt;
  logic                  line_start_r, line_start_nxt;
  logic                  fld_start_r, fld_start_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  accept;
  logic [7:0]            b, adj;
  logic                  hit;
  qfr_entry_t            ent;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;

  always_comb begin
    b              = in_chan.in_byte;
    adj            = b - qoff_r;
    hit            = $signed(adj) >= $signed({1'b0, qthr_r});
    fld_nxt        = fld_r;
    line_start_nxt = line_start_r;
    fld_start_nxt  = fld_start_r;
    cnt_nxt        = cnt_r;
    ent.lead       = line_start_r;
    ent.kind       = K_NONE;
    ent.data       = b;
    ent.count      = DEC_W'(64'(cnt_r));
    if (accept) begin
      line_start_nxt = 1'b0;
      priority if (b == CH_NL) begin
        ent.kind       = K_EOL;
        fld_nxt        = '0;
        line_start_nxt = 1'b1;
        fld_start_nxt  = 1'b1;
        cnt_nxt        = '0;
      end else if (b == CH_TAB) begin
        if (fld_r < FLD_DROP) begin
          ent.kind = K_BYTE;
          ent.data = qfr_tab_char(fld_r[2:0]);
        end else if (fld_r >= FLD_FLAG && fld_r <= FLD_QUAL) begin
          ent.kind = K_BYTE;
          ent.data = CH_TAB;
        end
        if (fld_r < FIELD_LIMIT) fld_nxt = fld_r + 4'd1;
        fld_start_nxt = 1'b1;
      end else begin
        fld_start_nxt = 1'b0;
        if (fld_r != FLD_DROP && fld_r <= FLD_LAST) begin
          ent.kind = K_BYTE;
        end
        if (fld_r == FLD_FLAG && fld_start_r && b == CH_THREE) begin
          ent.data = CH_TWO;
        end
        if (fld_r == FLD_BASES && b == CH_DOT) begin
          ent.data = CH_N;
        end
        if (fld_r == FLD_QUAL) begin
          ent.data = adj;
          if (hit && cnt_r < CAP) cnt_nxt = cnt_r + COUNT_BITS'(1);
        end
      end
    end
  end

  assign push      = accept && (line_start_r || ent.kind != K_NONE);
  assign push_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qoff_r       <= 8'd31;
      qthr_r       <= 7'd63;
      fld_r        <= '0;
      line_start_r <= 1'b1;
      fld_start_r  <= 1'b1;
      cnt_r        <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_QUAL_OFFSET) qoff_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_QUAL_THRESH) qthr_r <= cfg_wdata[6:0];
      fld_r        <= fld_nxt;
      line_start_r <= line_start_nxt;
      fld_start_r  <= fld_start_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/qfr_back.sv
// Back end: pops commands and drives the output register, one byte a cycle when not stalled,
// expanding end-of-line commands into the decimal trailer. Depends on qfr_pkg, qfr_if.
module qfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  qfr_pkg::qfr_entry_t q_head,
  output logic                q_pop,
  qfr_out_if.source           out_chan
);
  import qfr_pkg::*;

  typedef enum logic [2:0] {
    ST_GET, ST_LEAD, ST_BYTE, ST_TAB, ST_DIG, ST_NL
  } state_t;

  state_t           state_r, state_nxt;
  qfr_entry_t       cur_r, cur_nxt;
  logic [DEC_W-1:0] rem_r, rem_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic             started_r, started_nxt;
  logic             oval_r, oval_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic             olast_r, olast_nxt;

  logic             can_emit, done, load;
  logic [DEC_W-1:0] step, thr, sub;
  logic [3:0]       digit;
  logic             show;

  function automatic state_t first_state(input qfr_entry_t e);
    state_t s;
    if (e.lead)                s = ST_LEAD;
    else if (e.kind == K_BYTE) s = ST_BYTE;
    else                       s = ST_TAB;
    return s;
  endfunction

  assign can_emit = !oval_r || out_chan.ready;

  // one decimal digit per cycle unless the output stalls: compare against the nine multiples
  always_comb begin
    step  = DEC_STEP[pos_r];
    digit = '0;
    sub   = '0;
    thr   = '0;
    for (int k = 1; k <= 9; k++) begin
      thr = DEC_W'(step * DEC_W'(k));
      if (rem_r >= thr) begin
        digit = 4'(k);
        sub   = thr;
      end
    end
    show = started_r || (digit != 4'd0) || (pos_r == 3'(DIGITS - 1));
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    rem_nxt     = rem_r;
    pos_nxt     = pos_r;
    started_nxt = started_r;
    oval_nxt    = oval_r && !out_chan.ready;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;
    done        = 1'b0;
    unique case (state_r)
      ST_GET: ;
      ST_LEAD: begin
        if (can_emit) begin
          oval_nxt  = 1'b1;
          obyte_nxt = CH_AT;
          olast_nxt = (cur_r.kind == K_NONE);
          unique case (cur_r.kind)
            K_BYTE:  state_nxt = ST_BYTE;
            K_EOL:   state_nxt = ST_TAB;
            default: done = 1'b1;
          endcase
        end
      end
      ST_BYTE: begin
        if (can_emit) begin
          oval_nxt  = 1'b1;
          obyte_nxt = cur_r.data;
          olast_nxt = 1'b1;
          done      = 1'b1;
        end
      end
      ST_TAB: begin
        if (can_emit) begin
          oval_nxt  = 1'b1;
          obyte_nxt = CH_TAB;
          olast_nxt = 1'b0;
          state_nxt = ST_DIG;
        end
      end
      ST_DIG: begin
        if (!show || can_emit) begin
          if (show) begin
            oval_nxt    = 1'b1;
            obyte_nxt   = CH_ZERO + {4'd0, digit};
            olast_nxt   = 1'b0;
            started_nxt = 1'b1;
            rem_nxt     = rem_r - sub;
          end
          if (pos_r == 3'(DIGITS - 1)) state_nxt = ST_NL;
          else                         pos_nxt   = pos_r + 3'd1;
        end
      end
      ST_NL: begin
        if (can_emit) begin
          oval_nxt  = 1'b1;
          obyte_nxt = CH_NL;
          olast_nxt = 1'b1;
          done      = 1'b1;
        end
      end
      default: state_nxt = ST_GET;
    endcase

    if (done) state_nxt = ST_GET;
    load = ((state_r == ST_GET) || done) && !q_empty;
    if (load) begin
      cur_nxt     = q_head;
      state_nxt   = first_state(q_head);
      rem_nxt     = q_head.count;
      pos_nxt     = '0;
      started_nxt = 1'b0;
    end
  end

  assign q_pop                = load;
  assign out_chan.valid       = oval_r;
  assign out_chan.out_byte    = obyte_r;
  assign out_chan.last_of_run = olast_r;

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    rem_r   <= rem_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      state_r   <= ST_GET;
      pos_r     <= '0;
      started_r <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      started_r <= started_nxt;
      oval_r    <= oval_nxt;
    end
  end

endmodule

FILE: rtl/core/qseq_to_fastq_line_rewriter.sv
// Top level of the record line rewriter: front end, command queue, back end.
// Depends on qfr_pkg, qfr_if, qfr_front, qfr_queue, qfr_back.
//
//   channel   dir   transfer when          payload
//   in_chan   in    valid && ready         in_byte[7:0]
//   out_chan  out   valid && ready         out_byte[7:0], last_of_run
//   cfg_*     in    cfg_we (no handshake)  cfg_index[0], cfg_wdata[7:0]
//
// Flow: ordinary bytes stream at one per cycle once the queue is running and
//   the output is ready. The '@' at line start is one extra output byte. A
//   newline expands into tab, five decimal places (leading zeros skipped),
//   newline. The back end has a single output register.
// Reset: rst_n synchronous, active low; offset 31, threshold 63, line start.
// Stalls: the QUEUE_DEPTH-entry queue decouples input from output; in_chan
//   ready drops only when the queue is full.
module qseq_to_fastq_line_rewriter #(
  parameter int COUNT_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  qfr_in_if.sink     in_chan,
  qfr_out_if.source  out_chan
);
  import qfr_pkg::*;

  logic       push, pop, full, empty;
  qfr_entry_t push_data, head;

  // front: field tracking, quality count, command generation
  qfr_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .q_full    (full),
    .push      (push),
    .push_data (push_data)
  );

  // commands wait here while the back end drains a trailer or stalls
  qfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // back: byte emission and decimal trailer
  qfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (empty),
    .q_head   (head),
    .q_pop    (pop),
    .out_chan (out_chan)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for qseq_to_fastq_line_rewriter: directed rows, then random records
// under several quality settings.
// Depends on qfr_pkg and the qfr_in_if / qfr_out_if interfaces from the RTL.
module tb;
  import qfr_pkg::*;

  localparam int COUNT_BITS = 16;
  localparam longint unsigned COUNT_FULL = (64'd1 << COUNT_BITS) - 1;
  // The count saturates at the lesser of the counter width and five digits.
  localparam int unsigned COUNT_CAP =
    (COUNT_FULL < DIGIT_LIMIT) ? COUNT_FULL[31:0] : DIGIT_LIMIT;

  localparam int DRAIN_CYCLES = 40;    // room for a full queue of newline trailers, plus slack
  localparam int STALL_LIMIT  = 1000;  // cycles without any transfer before giving up
  localparam int HOLD_AT      = 120;   // output transfers before the long back-pressure
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 24;    // minimum productive input bytes per random phase
  localparam int MAX_REPORTS  = 200;   // keep the log readable if the stream slips

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } out_beat_t;

  // One directed row: input byte plus, where n >= 0, the output typed in by hand.
  // Bytes of want are right-aligned, first output byte most significant.
  typedef struct {
    logic [7:0]  in_b;
    int          n;
    logic [55:0] want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_wdata;

  qfr_in_if  in_ch ();
  qfr_out_if out_ch ();

  qseq_to_fastq_line_rewriter #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_ch),
    .out_chan  (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line rewriting predictor: its own copy of the field tracker and registers.
  // ---------------------------------------------------------------------------
  logic [3:0]  fld_idx;
  bit          line_head;
  bit          field_head;
  int unsigned hq_count;
  logic [7:0]  q_offset;
  logic [6:0]  q_thresh;

  logic [7:0]  run_bytes[$];       // bytes caused by the byte just transferred
  out_beat_t   expected_beats[$];  // outputs still owed by the block
  stim_row_t   stim_table[$];

  bit gaps_on;
  int errors = 0;
  int beats_seen = 0;
  int phase_items;

  function automatic void reset_predictor();
    fld_idx    = '0;
    line_head  = 1'b1;
    field_head = 1'b1;
    hq_count   = 0;
    q_offset   = 8'd31;
    q_thresh   = 7'd63;
  endfunction

  // Tabs that close the header fields 0..5 turn into separators.
  function automatic logic [7:0] header_sep(input logic [3:0] f);
    case (f)
      4'd0:    return CH_UNDER;
      4'd5:    return CH_SLASH;
      default: return CH_COLON;
    endcase
  endfunction

  function automatic void rewrite_byte(input logic [7:0] b);
    logic [7:0]  o;
    int          sv;
    int unsigned c;
    int unsigned place;
    int unsigned d;
    int          k;
    bit          lead;
    run_bytes.delete();
    if (line_head) run_bytes.push_back(CH_AT);
    line_head = 1'b0;
    if (b == CH_NL) begin
      // Trailer: tab, count in decimal without leading zeros, newline.
      c = (hq_count > DIGIT_LIMIT) ? DIGIT_LIMIT : hq_count;
      run_bytes.push_back(CH_TAB);
      place = 10000;
      lead  = 1'b1;
      for (k = 0; k < DIGITS; k++) begin
        d = c / place;
        c = c % place;
        if (d != 0 || !lead || k == DIGITS - 1) begin
          run_bytes.push_back(CH_ZERO + d[7:0]);
          lead = 1'b0;
        end
        place = place / 10;
      end
      run_bytes.push_back(CH_NL);
      fld_idx    = '0;
      line_head  = 1'b1;
      field_head = 1'b1;
      hq_count   = 0;
    end else if (b == CH_TAB) begin
      if (fld_idx < FLD_DROP) run_bytes.push_back(header_sep(fld_idx));
      else if (fld_idx >= FLD_FLAG && fld_idx <= FLD_QUAL) run_bytes.push_back(CH_TAB);
      if (fld_idx < FIELD_LIMIT) fld_idx++;
      field_head = 1'b1;
    end else begin
      o = b;
      if (fld_idx == FLD_FLAG && field_head && b == CH_THREE) begin
        o = CH_TWO;
      end else if (fld_idx == FLD_BASES && b == CH_DOT) begin
        o = CH_N;
      end else if (fld_idx == FLD_QUAL) begin
        // Offset wraps mod 256; the threshold compare is signed.
        o  = b - q_offset;
        sv = o[7] ? int'(o) - 256 : int'(o);
        if (sv >= int'(q_thresh) && hq_count < COUNT_CAP) hq_count++;
      end
      if (fld_idx != FLD_DROP && fld_idx <= FLD_LAST) run_bytes.push_back(o);
      field_head = 1'b0;
    end
  endfunction

  function automatic void add_row(input logic [7:0] b, input int n, input logic [55:0] want);
    stim_row_t r;
    r.in_b = b;
    r.n    = n;
    r.want = want;
    stim_table.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. One transfer per call; valid stays high into the next call
  // unless a random gap drops it, so back-to-back transfers never toggle it.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input int typed_n, input logic [55:0] typed);
    int        k;
    out_beat_t beat;
    while (gaps_on && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Transfer happened at this edge; predictor state always advances.
    rewrite_byte(b);
    if (typed_n >= 0) begin
      run_bytes.delete();
      for (k = 0; k < typed_n; k++) run_bytes.push_back(typed[(typed_n - 1 - k) * 8 +: 8]);
    end
    for (k = 0; k < run_bytes.size(); k++) begin
      beat.data    = run_bytes[k];
      beat.is_last = (k == run_bytes.size() - 1);
      expected_beats.push_back(beat);
    end
    if (run_bytes.size() != 0) phase_items++;
  endtask

  // Drop valid, wait for every owed output, then let any dropped byte still
  // in the pipe drain before touching the registers.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Threshold data bit 7 is ignored by the block; only bits 6:0 are meaningful.
  task automatic set_quality(input logic [7:0] off, input logic [7:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_QUAL_OFFSET;
    cfg_wdata <= off;
    @(posedge clk);
    cfg_index <= CFG_QUAL_THRESH;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we   <= 1'b0;
    q_offset = off;
    q_thresh = thr[6:0];
  endtask

  // Mostly well-formed records with random content; some short lines and
  // some pure noise (any byte, tabs and newlines included).
  task automatic send_record();
    int         f;
    int         n_fields;
    int         len;
    int         j;
    logic [7:0] b;
    if ($urandom_range(99) < 15) begin
      len = $urandom_range(24, 1);
      for (j = 0; j < len; j++) begin
        b = 8'($urandom_range(255));
        if ($urandom_range(7) == 0) b = CH_TAB;
        send_item(b, -1, '0);
      end
    end else begin
      n_fields = ($urandom_range(9) == 0) ? $urandom_range(10, 1) : $urandom_range(13, 11);
      for (f = 0; f < n_fields; f++) begin
        if (f != 0) send_item(CH_TAB, -1, '0);
        len = (f == FLD_QUAL) ? $urandom_range(6) : $urandom_range(3);
        for (j = 0; j < len; j++) begin
          do b = 8'($urandom_range(255)); while (b == CH_TAB || b == CH_NL);
          if (f == FLD_FLAG && j == 0 && $urandom_range(1) == 1) b = CH_THREE;
          if (f == FLD_BASES && $urandom_range(2) == 0) b = CH_DOT;
          send_item(b, -1, '0);
        end
      end
    end
    send_item(CH_NL, -1, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         k;
    int         p;
    stim_row_t  r;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_QUAL_OFFSET;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    gaps_on       <= 1'b1;
    phase_items = 0;
    reset_predictor();

    // Directed walk with reset settings (offset 31, threshold 63).
    add_row(CH_NL,     4, {CH_AT, CH_TAB, CH_ZERO, CH_NL});  // empty line
    add_row(8'h00,     2, {CH_AT, 8'h00});                   // NUL is plain content
    add_row(CH_TAB,    1, {CH_UNDER});
    add_row(8'hFF,     1, {8'hFF});
    add_row(CH_TAB,    1, {CH_COLON});
    add_row(CH_TAB,    1, {CH_COLON});                       // empty field
    add_row(CH_TAB,    1, {CH_COLON});
    add_row(8'h0D,     1, {8'h0D});                          // CR is plain content
    add_row(CH_TAB,    1, {CH_COLON});
    add_row(CH_TAB,    1, {CH_SLASH});
    add_row(8'h41,     0, '0);                               // field 6 dropped
    add_row(CH_TAB,    0, '0);                               // ...with its tab
    add_row(CH_THREE,  1, {CH_TWO});                         // leading '3' of field 7
    add_row(CH_THREE,  1, {CH_THREE});                       // not leading: kept
    add_row(CH_TAB,    1, {CH_TAB});
    add_row(CH_DOT,    1, {CH_N});
    add_row(CH_TAB,    1, {CH_TAB});
    add_row(8'h80,     -1, '0);                              // quality bytes
    add_row(8'h5E,     -1, '0);                              // exactly at threshold
    add_row(8'h5D,     -1, '0);                              // one below
    add_row(CH_TAB,    1, {CH_TAB});
    add_row(CH_THREE,  1, {CH_THREE});                       // field 10 unchanged
    add_row(CH_TAB,    0, '0);                               // tab after field 10 dropped
    add_row(8'h78,     0, '0);                               // field 11 dropped
    add_row(CH_TAB,    0, '0);
    add_row(CH_NL,     -1, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < stim_table.size(); k++) begin
      r = stim_table[k];
      send_item(r.in_b, r.n, r.want);
    end

    // Random phases: each starts idle, then gets a new quality setting.
    // Extremes first; phase 3 runs without any gaps on either side.
    for (p = 0; p < 6; p++) begin
      settle();
      case (p)
        0:       set_quality(8'h00, 8'h00);
        1:       set_quality(8'hFF, 8'hFF);
        2:       set_quality(8'h00, 8'h7F);
        3:       set_quality(8'hFF, 8'h80);
        default: set_quality(8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
      gaps_on     <= (p != 3);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_record();
    end

    settle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random ready, plus one long hold-off once traffic is flowing
  // so the internal queue fills and the input channel has to stall.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && beats_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < 6);
      end
    end
  end

  // Compare each output transfer against the oldest owed byte.
  always @(posedge clk) begin : out_check
    out_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen <= beats_seen + 1;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("out_byte: nothing expected, actual %h", out_ch.out_byte);
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.out_byte !== want.data) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $error("out_byte: expected %h, actual %h", want.data, out_ch.out_byte);
        end
        if (out_ch.last_of_run !== want.is_last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $error("last_of_run: expected %0d, actual %0d", want.is_last, out_ch.last_of_run);
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end while (quiet < STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/qfr_pkg.sv
rtl/core/qfr_if.sv
rtl/core/qfr_queue.sv
rtl/core/qfr_front.sv
rtl/core/qfr_back.sv
rtl/core/qseq_to_fastq_line_rewriter.sv
tb/tb.sv
